### rtl/core/jppi_pkg.sv
package jppi_pkg;

    localparam int CHAR_W    = 21;
    localparam int DEPTH_W   = 4;
    localparam int SPACE_W   = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [CHAR_W-1:0] CH_TAB     = 21'h00009;
    localparam logic [CHAR_W-1:0] CH_NL      = 21'h0000A;
    localparam logic [CHAR_W-1:0] CH_CR      = 21'h0000D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 21'h00020;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 21'h00022;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 21'h0002C;
    localparam logic [CHAR_W-1:0] CH_COLON   = 21'h0003A;
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 21'h0005B;
    localparam logic [CHAR_W-1:0] CH_BSLASH  = 21'h0005C;
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 21'h0005D;
    localparam logic [CHAR_W-1:0] CH_LBRACE  = 21'h0007B;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 21'h0007D;

    typedef logic [2:0] cmd_kind_t;

    localparam cmd_kind_t CMD_PASS  = 3'd0;
    localparam cmd_kind_t CMD_OPEN  = 3'd1;
    localparam cmd_kind_t CMD_CLOSE = 3'd2;
    localparam cmd_kind_t CMD_COMMA = 3'd3;
    localparam cmd_kind_t CMD_COLON = 3'd4;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [CHAR_W-1:0]    ch;
        logic [SPACE_W-1:0]   spaces;
    } cmd_t;

endpackage

### rtl/core/json_pretty_print_indenter_core.sv
// Pretty-prints compact JSON one code point per input item. The back end
// writes one output character per cycle while out_stall is low, so an ordinary
// character yields one output character, a colon in spaced mode three, and a
// bracket or comma two plus INDENT_WIDTH spaces per nesting level. A four-entry
// command queue sits between the classifier and the output sequencer; in_stall
// rises only when that queue is full. Whitespace outside strings is dropped and
// produces no output. Nesting depth saturates at 0 and MAX_DEPTH.
module json_pretty_print_indenter_core
    import jppi_pkg::*;
#(
    parameter int MAX_DEPTH    = 15,
    parameter int INDENT_WIDTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] in_char,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              last
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    jppi_front #(
        .MAX_DEPTH    (MAX_DEPTH),
        .INDENT_WIDTH (INDENT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_char     (in_char),
        .push        (push),
        .cmd         (push_cmd)
    );

    jppi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    jppi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last       (last)
    );

endmodule

### rtl/core/jppi_front.sv
module jppi_front
    import jppi_pkg::*;
#(
    parameter int MAX_DEPTH    = 15,
    parameter int INDENT_WIDTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              accept,
    input  logic [CHAR_W-1:0] in_char,
    output logic              push,
    output cmd_t              cmd
);

    localparam logic [DEPTH_W-1:0] MAX_D  = DEPTH_W'(MAX_DEPTH);
    localparam logic [SPACE_W-1:0] IND_W  = SPACE_W'(INDENT_WIDTH);

    logic               escape_reg, escape_next;
    logic               string_reg, string_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               colon_spaced_reg;
    logic               emit;
    cmd_kind_t          kind;

    always_comb
    begin
        escape_next = escape_reg;
        string_next = string_reg;
        depth_next  = depth_reg;
        emit        = 1'b1;
        kind        = CMD_PASS;
        if (escape_reg)
        begin
            escape_next = 1'b0;
        end
        else if (in_char == CH_BSLASH)
        begin
            escape_next = 1'b1;
        end
        else if (in_char == CH_QUOTE)
        begin
            string_next = !string_reg;
        end
        else if (string_reg)
        begin
            kind = CMD_PASS;
        end
        else if (in_char == CH_LBRACE || in_char == CH_LBRACK)
        begin
            kind = CMD_OPEN;
            if (depth_reg < MAX_D)
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
        else if (in_char == CH_RBRACE || in_char == CH_RBRACK)
        begin
            kind = CMD_CLOSE;
            if (depth_reg != '0)
            begin
                depth_next = depth_reg - 1'b1;
            end
        end
        else if (in_char == CH_COMMA)
        begin
            kind = CMD_COMMA;
        end
        else if (in_char == CH_COLON)
        begin
            kind = colon_spaced_reg ? CMD_COLON : CMD_PASS;
        end
        else if (in_char == CH_SPACE || (in_char >= CH_TAB && in_char <= CH_CR))
        begin
            emit = 1'b0;
        end
    end

    assign push       = accept && emit;
    assign cmd.kind   = kind;
    assign cmd.ch     = in_char;
    assign cmd.spaces = SPACE_W'(depth_next) * IND_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg       <= 1'b0;
            string_reg       <= 1'b0;
            depth_reg        <= '0;
            colon_spaced_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                escape_reg <= escape_next;
                string_reg <= string_next;
                depth_reg  <= depth_next;
            end
            if (cfg_wr_en)
            begin
                colon_spaced_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### rtl/core/jppi_queue.sv
module jppi_queue
    import jppi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/jppi_back.sv
module jppi_back
    import jppi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  cmd_t              head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              last
);

    localparam logic [1:0] ST_FIRST  = 2'd0;
    localparam logic [1:0] ST_SECOND = 2'd1;
    localparam logic [1:0] ST_SPACES = 2'd2;
    localparam logic [1:0] ST_TAIL   = 2'd3;

    logic [1:0]         st_reg, st_next;
    logic [SPACE_W-1:0] sp_cnt_reg, sp_cnt_next;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               last_reg;
    logic               emit;
    logic [CHAR_W-1:0]  cur_char;
    logic               cur_last;
    logic               no_spaces;
    logic               spaces_done;

    assign emit        = head_valid && (!out_valid_reg || !out_stall);
    assign no_spaces   = (head_cmd.spaces == '0);
    assign spaces_done = (sp_cnt_reg == head_cmd.spaces - 1'b1);

    always_comb
    begin
        cur_char    = head_cmd.ch;
        cur_last    = 1'b0;
        st_next     = st_reg;
        sp_cnt_next = sp_cnt_reg;
        unique case (st_reg)
            ST_FIRST:
            begin
                sp_cnt_next = '0;
                unique case (head_cmd.kind)
                    CMD_OPEN, CMD_COMMA:
                    begin
                        st_next = ST_SECOND;
                    end
                    CMD_CLOSE:
                    begin
                        cur_char = CH_NL;
                        st_next  = no_spaces ? ST_TAIL : ST_SPACES;
                    end
                    CMD_COLON:
                    begin
                        cur_char = CH_SPACE;
                        st_next  = ST_SECOND;
                    end
                    default:
                    begin
                        cur_last = 1'b1;
                    end
                endcase
            end
            ST_SECOND:
            begin
                if (head_cmd.kind == CMD_COLON)
                begin
                    cur_char = CH_COLON;
                    st_next  = ST_TAIL;
                end
                else
                begin
                    cur_char = CH_NL;
                    if (no_spaces)
                    begin
                        cur_last = 1'b1;
                        st_next  = ST_FIRST;
                    end
                    else
                    begin
                        st_next = ST_SPACES;
                    end
                end
            end
            ST_SPACES:
            begin
                cur_char    = CH_SPACE;
                sp_cnt_next = sp_cnt_reg + 1'b1;
                if (spaces_done)
                begin
                    if (head_cmd.kind == CMD_CLOSE)
                    begin
                        st_next = ST_TAIL;
                    end
                    else
                    begin
                        cur_last = 1'b1;
                        st_next  = ST_FIRST;
                    end
                end
            end
            ST_TAIL:
            begin
                cur_char = (head_cmd.kind == CMD_COLON) ? CH_SPACE : head_cmd.ch;
                cur_last = 1'b1;
                st_next  = ST_FIRST;
            end
            default:
            begin
                st_next = ST_FIRST;
            end
        endcase
    end

    assign pop       = emit && cur_last;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_FIRST;
            sp_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                st_reg        <= st_next;
                sp_cnt_reg    <= sp_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg <= cur_char;
            last_reg     <= cur_last;
        end
    end

endmodule

### tb/tb_json_pretty_print_indenter_core.sv
module tb_json_pretty_print_indenter_core;
    import jppi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEST_MAX    = 15;
    localparam int INDENT_STEP = 4;
    localparam int DRAIN_WAIT  = 300;

    localparam logic [CHAR_W-1:0] CH_VT  = 21'h0000B;
    localparam logic [CHAR_W-1:0] CH_FF  = 21'h0000C;
    localparam logic [CHAR_W-1:0] CH_MAX = 21'h1FFFFF;
    localparam logic [CHAR_W-1:0] CH_TOP = 21'h10FFFF;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } pretty_char_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] in_char;
    logic              out_valid;
    logic              out_stall;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    pretty_char_t       pretty_chars_due[$];
    logic               escape_armed;
    logic               in_string;
    logic [DEPTH_W-1:0] nest_level;
    logic               colon_spaced_q;
    bit                 idle_on;
    int                 mismatches;

    json_pretty_print_indenter_core #(
        .MAX_DEPTH    (NEST_MAX),
        .INDENT_WIDTH (INDENT_STEP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic void push_pretty(input logic [CHAR_W-1:0] c);
        pretty_char_t p;
        p.ch   = c;
        p.last = 1'b0;
        pretty_chars_due = {pretty_chars_due, p};
    endfunction

    function automatic void push_indent(input logic [DEPTH_W-1:0] levels);
        for (int i = 0; i < levels * INDENT_STEP; i++)
            push_pretty(CH_SPACE);
    endfunction

    // Expected layout of one code point; updates escape, string and depth state.
    function automatic void format_char(input logic [CHAR_W-1:0] c);
        int           n_before;
        pretty_char_t tail;
        n_before = pretty_chars_due.size();
        if (escape_armed)
        begin
            escape_armed = 1'b0;
            push_pretty(c);
        end
        else if (c == CH_BSLASH)
        begin
            escape_armed = 1'b1;
            push_pretty(c);
        end
        else if (c == CH_QUOTE)
        begin
            in_string = ~in_string;
            push_pretty(c);
        end
        else if (in_string)
            push_pretty(c);
        else if (c == CH_LBRACE || c == CH_LBRACK)
        begin
            push_pretty(c);
            push_pretty(CH_NL);
            if (nest_level < NEST_MAX)
                nest_level = nest_level + 1'b1;
            push_indent(nest_level);
        end
        else if (c == CH_RBRACE || c == CH_RBRACK)
        begin
            push_pretty(CH_NL);
            if (nest_level > 0)
                nest_level = nest_level - 1'b1;
            push_indent(nest_level);
            push_pretty(c);
        end
        else if (c == CH_COMMA)
        begin
            push_pretty(c);
            push_pretty(CH_NL);
            push_indent(nest_level);
        end
        else if (c == CH_COLON)
        begin
            if (colon_spaced_q)
            begin
                push_pretty(CH_SPACE);
                push_pretty(CH_COLON);
                push_pretty(CH_SPACE);
            end
            else
                push_pretty(CH_COLON);
        end
        else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
            push_pretty(c);
        if (pretty_chars_due.size() > n_before)
        begin
            tail = pretty_chars_due.pop_back();
            tail.last = 1'b1;
            pretty_chars_due = {pretty_chars_due, tail};
        end
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        format_char(c);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(CHAR_W'(s[i]));
    endtask

    // Drop valid, drain all due characters, then let the back end settle.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pretty_chars_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_colon_spacing(input logic spaced);
        settle_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= spaced;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        colon_spaced_q = spaced;
    endtask

    function automatic logic [CHAR_W-1:0] rand_code_point();
        return CHAR_W'($urandom_range(0, 32'h1FFFFF));
    endfunction

    task automatic test_basic_layout();
        send_text("{\"k\":[1,2], \"\":}");
    endtask

    task automatic test_blanks_escapes_extremes();
        send_char(CH_RBRACK);
        send_char(CH_TAB);
        send_char(CH_NL);
        send_char(CH_VT);
        send_char(CH_FF);
        send_char(CH_CR);
        send_char(CH_SPACE);
        send_char('0);
        send_char(CH_MAX);
        send_char(CH_TOP);
        send_char(CH_BSLASH);
        send_char(CH_LBRACE);
        send_char(CH_BSLASH);
        send_char(CH_SPACE);
        send_text("\" \t\\\"x\"");
    endtask

    task automatic test_spaced_colon();
        send_text("\"a\":7:");
    endtask

    task automatic test_depth_saturation();
        repeat (NEST_MAX + 2) send_char(CH_LBRACK);
        send_char(CH_COMMA);
        repeat (NEST_MAX + 2) send_char(CH_RBRACE);
    endtask

    task automatic test_random_json(input int target, input bit allow_idle);
        int n;
        int roll;
        int gen_depth;
        n = 0;
        gen_depth = 0;
        while (n < target)
        begin
            idle_on = allow_idle && (n % 40 < 30 || $urandom_range(0, 1) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 15 || (roll < 30 && gen_depth == 0 && roll < 22))
            begin
                send_char($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
                gen_depth++;
                n++;
            end
            else if (roll < 30)
            begin
                send_char($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
                if (gen_depth > 0)
                    gen_depth--;
                n++;
            end
            else if (roll < 42)
            begin
                send_char(CH_COMMA);
                n++;
            end
            else if (roll < 52)
            begin
                send_char(CH_COLON);
                n++;
            end
            else if (roll < 78)
            begin
                send_char(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_char(CH_BSLASH);
                        send_char(rand_code_point());
                        n += 2;
                    end
                    else
                    begin
                        send_char($urandom_range(0, 3) == 0 ? rand_code_point()
                                  : CHAR_W'($urandom_range(32'h23, 32'h5B)));
                        n++;
                    end
                end
                send_char(CH_QUOTE);
                n += 2;
            end
            else if (roll < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_char($urandom_range(0, 1) ? CHAR_W'($urandom_range(32'h30, 32'h39))
                              : CHAR_W'($urandom_range(32'h5E, 32'h7A)));
                    n++;
                end
            end
            else if (roll < 95)
            begin
                case ($urandom_range(0, 5))
                    0: send_char(CH_SPACE);
                    1: send_char(CH_TAB);
                    2: send_char(CH_NL);
                    3: send_char(CH_VT);
                    4: send_char(CH_FF);
                    default: send_char(CH_CR);
                endcase
            end
            else
            begin
                send_char(rand_code_point());
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        in_valid       = 1'b0;
        in_char        = '0;
        escape_armed   = 1'b0;
        in_string      = 1'b0;
        nest_level     = '0;
        colon_spaced_q = 1'b0;
        idle_on        = 1'b1;
        mismatches     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_layout();
        test_blanks_escapes_extremes();
        set_colon_spacing(1'b1);
        test_spaced_colon();
        test_depth_saturation();
        test_random_json(130, 1'b1);
        set_colon_spacing(1'b0);
        test_random_json(130, 1'b1);
        set_colon_spacing(1'b1);
        idle_on = 1'b0;
        test_random_json(120, 1'b0);

        settle_idle();
        if (mismatches == 0)
            $display("json_pretty_print_indenter_core regression: pass");
        else
            $display("json_pretty_print_indenter_core regression: fail");
        $finish;
    end

    initial
    begin
        pretty_char_t due;
        int           stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pretty_chars_due.size() == 0)
                begin
                    $error("out_char: unexpected item %h, last %b", out_char, last);
                    mismatches++;
                end
                else
                begin
                    due = pretty_chars_due.pop_front();
                    if (out_char !== due.ch)
                    begin
                        $error("out_char: expected %h, got %h", due.ch, out_char);
                        mismatches++;
                    end
                    if (last !== due.last)
                    begin
                        $error("last: expected %b, got %b", due.last, last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #50_000_000;
        $display("json_pretty_print_indenter_core regression: fail");
        $finish;
    end

endmodule
